[rtl/core/mlic_pkg.sv]
// ----------------------------------------------------------------------------
// mlic_pkg
// Shared types, codes and constants of the marker list intersect counter.
// ----------------------------------------------------------------------------
package mlic_pkg;

  localparam int ROW_TABLE_DEPTH_DEF    = 1024;
  localparam int COLUMN_TABLE_DEPTH_DEF = 4096;
  localparam int MARKER_DEPTH_DEF       = 1024;

  localparam int MODE_W   = 2;
  localparam int ADDR_W   = 12;
  localparam int VALUE_W  = 13;
  localparam int BASE_W   = 10;
  localparam int ROWNUM_W = 10;
  localparam int TOTAL_W  = 24;
  localparam int OFFSET_W = 13;
  localparam int COL_W    = 10;
  localparam int MARKER_W = 11;
  localparam int ROW_W    = 11;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_WR_ROW = 2'd0;
  localparam mode_t MODE_WR_COL = 2'd1;
  localparam mode_t MODE_CLEAR  = 2'd2;
  localparam mode_t MODE_COUNT  = 2'd3;

  localparam logic [MARKER_W-1:0] MARKER_EMPTY = 11'h7FF;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = 24'hFFFFFF;

  // Which row a span lookup serves
  typedef logic [1:0] phase_t;

  localparam phase_t PHASE_AC = 2'd0;
  localparam phase_t PHASE_AB = 2'd1;
  localparam phase_t PHASE_BC = 2'd2;

  typedef struct packed {
    logic   cap;
    phase_t phase;
    logic   span_empty;
    logic   row_rd_lo;
    logic   row_rd_hi;
    logic   span_cap_lo;
    logic   span_cap_hi;
    logic   col_rd_a;
    logic   col_rd_b;
    logic   stamp_wr;
    logic   b_lat;
    logic   mk_rd;
    logic   cmp;
    logic   clr_step;
    logic   out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic row_bad;
    logic a_more;
    logic b_more;
    logic clr_more;
  } dp_status_t;

endpackage

[rtl/core/mlic_in_if.sv]
// ----------------------------------------------------------------------------
// mlic_in_if
// Input item channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface mlic_in_if;
  logic                                valid;
  logic                                ready;
  mlic_pkg::mode_t                     mode;
  logic [mlic_pkg::ADDR_W-1:0]         address;
  logic [mlic_pkg::VALUE_W-1:0]        value;
  logic [mlic_pkg::BASE_W-1:0]         ab_base;
  logic [mlic_pkg::BASE_W-1:0]         bc_base;
  logic [mlic_pkg::BASE_W-1:0]         ac_base;
  logic [mlic_pkg::ROWNUM_W-1:0]       row_number;

  modport source (
    output valid, mode, address, value, ab_base, bc_base, ac_base, row_number,
    input  ready
  );

  modport sink (
    input  valid, mode, address, value, ab_base, bc_base, ac_base, row_number,
    output ready
  );
endinterface

[rtl/core/mlic_out_if.sv]
// ----------------------------------------------------------------------------
// mlic_out_if
// Result item channel: valid/ready handshake with the count result.
// ----------------------------------------------------------------------------
interface mlic_out_if;
  logic                          valid;
  logic                          ready;
  logic [mlic_pkg::TOTAL_W-1:0]  match_total;
  logic                          range_error;

  modport source (
    output valid, match_total, range_error,
    input  ready
  );

  modport sink (
    input  valid, match_total, range_error,
    output ready
  );
endinterface

[rtl/core/mlic_ram.sv]
// ----------------------------------------------------------------------------
// mlic_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mlic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/mlic_ctrl.sv]
// ----------------------------------------------------------------------------
// mlic_ctrl
// Sequencer: runs marker clear sweeps, walks row spans, stamps markers, intersects lists,
// and hands the finished count to the result register.
// ----------------------------------------------------------------------------
module mlic_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  mlic_pkg::mode_t        in_mode,
  output logic                   in_ready,
  input  logic                   out_ready,
  output logic                   out_valid,
  output mlic_pkg::ctrl_cmd_t    cmd,
  input  mlic_pkg::dp_status_t   sts
);
  import mlic_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLR      = 4'd1;
  localparam logic [3:0] S_SPAN_LO  = 4'd2;
  localparam logic [3:0] S_SPAN_HI  = 4'd3;
  localparam logic [3:0] S_SPAN_CAP = 4'd4;
  localparam logic [3:0] S_ST_RD    = 4'd5;
  localparam logic [3:0] S_ST_WR    = 4'd6;
  localparam logic [3:0] S_A_RD     = 4'd7;
  localparam logic [3:0] S_A_LAT    = 4'd8;
  localparam logic [3:0] S_B_RD     = 4'd9;
  localparam logic [3:0] S_B_MK     = 4'd10;
  localparam logic [3:0] S_B_CMP    = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0] state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] loop_st;

  // Where a finished span lookup continues
  always_comb begin
    unique case (phase_r)
      PHASE_AC: loop_st = S_ST_RD;
      PHASE_AB: loop_st = S_A_RD;
      default:  loop_st = S_B_RD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.phase = phase_r;
    state_nxt = state_r;
    phase_nxt = phase_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          unique case (in_mode)
            MODE_CLEAR: state_nxt = S_CLR;
            MODE_COUNT: begin
              state_nxt = S_SPAN_LO;
              phase_nxt = PHASE_AC;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        if (sts.clr_more) begin
          cmd.clr_step = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SPAN_LO: begin
        if (sts.row_bad) begin
          cmd.span_empty = 1'b1;
          state_nxt      = loop_st;
        end else begin
          cmd.row_rd_lo = 1'b1;
          state_nxt     = S_SPAN_HI;
        end
      end
      S_SPAN_HI: begin
        cmd.row_rd_hi   = 1'b1;
        cmd.span_cap_lo = 1'b1;
        state_nxt       = S_SPAN_CAP;
      end
      S_SPAN_CAP: begin
        cmd.span_cap_hi = 1'b1;
        state_nxt       = loop_st;
      end
      S_ST_RD: begin
        if (sts.a_more) begin
          cmd.col_rd_a = 1'b1;
          state_nxt    = S_ST_WR;
        end else begin
          phase_nxt = PHASE_AB;
          state_nxt = S_SPAN_LO;
        end
      end
      S_ST_WR: begin
        cmd.stamp_wr = 1'b1;
        state_nxt    = S_ST_RD;
      end
      S_A_RD: begin
        if (sts.a_more) begin
          cmd.col_rd_a = 1'b1;
          state_nxt    = S_A_LAT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_A_LAT: begin
        cmd.b_lat = 1'b1;
        phase_nxt = PHASE_BC;
        state_nxt = S_SPAN_LO;
      end
      S_B_RD: begin
        if (sts.b_more) begin
          cmd.col_rd_b = 1'b1;
          state_nxt    = S_B_MK;
        end else begin
          phase_nxt = PHASE_AB;
          state_nxt = S_A_RD;
        end
      end
      S_B_MK: begin
        cmd.mk_rd = 1'b1;
        state_nxt = S_B_CMP;
      end
      S_B_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_B_RD;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      phase_r     <= PHASE_AC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/core/mlic_dp.sv]
// ----------------------------------------------------------------------------
// mlic_dp
// Datapath: row offset, column index and marker stores, list pointers,
// clear sweep counter, match total and the result register.
// ----------------------------------------------------------------------------
module mlic_dp #(
  parameter int ROW_TABLE_DEPTH    = 1024,
  parameter int COLUMN_TABLE_DEPTH = 4096,
  parameter int MARKER_DEPTH       = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mlic_pkg::mode_t               in_mode,
  input  logic [mlic_pkg::ADDR_W-1:0]   in_address,
  input  logic [mlic_pkg::VALUE_W-1:0]  in_value,
  input  logic [mlic_pkg::BASE_W-1:0]   in_ab_base,
  input  logic [mlic_pkg::BASE_W-1:0]   in_bc_base,
  input  logic [mlic_pkg::BASE_W-1:0]   in_ac_base,
  input  logic [mlic_pkg::ROWNUM_W-1:0] in_row_number,
  input  mlic_pkg::ctrl_cmd_t           cmd,
  output mlic_pkg::dp_status_t          sts,
  output logic [mlic_pkg::TOTAL_W-1:0]  out_match_total,
  output logic                          out_range_error
);
  import mlic_pkg::*;

  localparam int RA    = $clog2(ROW_TABLE_DEPTH);
  localparam int CA    = $clog2(COLUMN_TABLE_DEPTH);
  localparam int MA    = $clog2(MARKER_DEPTH);
  localparam int CLR_W = $clog2(MARKER_DEPTH + 1);

  localparam logic [31:0] RTD32 = 32'(ROW_TABLE_DEPTH);
  localparam logic [31:0] CTD32 = 32'(COLUMN_TABLE_DEPTH);
  localparam logic [31:0] MD32  = 32'(MARKER_DEPTH);
  localparam logic [CLR_W-1:0] MD_CNT = MD32[CLR_W-1:0];

  // Latched item fields and the latched ab-row column
  logic [ROWNUM_W-1:0] stamp_r;
  logic [BASE_W-1:0]   ab_base_r, bc_base_r, ac_base_r;
  logic [COL_W-1:0]    b_r;

  // List walk pointers
  logic [OFFSET_W-1:0] a_ptr_r, a_hi_r, b_ptr_r, b_hi_r, lo_r;

  logic [CLR_W-1:0]    clr_cnt_r, clr_lim_r;
  logic [TOTAL_W-1:0]  total_r, out_total_r;
  logic                err_r, out_err_r, hit_v_r;

  // Row select and span bounds
  logic [BASE_W-1:0]   base_sel;
  logic [COL_W-1:0]    off_sel;
  logic [ROW_W-1:0]    row_sum;
  logic [ROW_W:0]      row_inc, row_rd_idx;
  logic [31:0]         row_inc32, row_addr32;
  logic [OFFSET_W-1:0] row_rdata, hi_cl, lo_cl;
  logic                hi_over;

  logic [31:0]         waddr32, value32, lim32, col_ptr32, col32, clr32;
  logic [CLR_W-1:0]    clr_lim_in;
  logic [OFFSET_W-1:0] col_ptr;
  logic [COL_W-1:0]    col_rdata;
  logic                col_ok;
  logic [MARKER_W-1:0] mk_rdata, mk_wdata;
  logic [MA-1:0]       mk_waddr;
  logic                mk_we;

  logic                row_we, col_we, dst_b;

  always_comb begin
    unique case (cmd.phase)
      PHASE_AC: base_sel = ac_base_r;
      PHASE_AB: base_sel = ab_base_r;
      default:  base_sel = bc_base_r;
    endcase
  end

  assign dst_b      = (cmd.phase == PHASE_BC);
  assign off_sel    = dst_b ? b_r : stamp_r;
  assign row_sum    = {1'b0, base_sel} + {1'b0, off_sel};
  assign row_inc    = {1'b0, row_sum} + (ROW_W+1)'(1);
  assign row_inc32  = 32'(row_inc);
  assign row_rd_idx = cmd.row_rd_hi ? row_inc : {1'b0, row_sum};
  assign row_addr32 = 32'(row_rd_idx);

  // Clamp the row end to the column table and keep the start at or below it
  assign hi_over = (32'(row_rdata) > CTD32);
  assign hi_cl   = hi_over ? CTD32[OFFSET_W-1:0] : row_rdata;
  assign lo_cl   = (lo_r > hi_cl) ? hi_cl : lo_r;

  assign waddr32 = 32'(in_address);
  assign value32 = 32'(in_value);
  assign lim32   = (value32 > MD32) ? MD32 : value32;
  assign clr_lim_in = lim32[CLR_W-1:0];

  assign row_we = cmd.cap && (in_mode == MODE_WR_ROW) && (waddr32 < RTD32);
  assign col_we = cmd.cap && (in_mode == MODE_WR_COL) && (waddr32 < CTD32);

  assign col_ptr   = cmd.col_rd_b ? b_ptr_r : a_ptr_r;
  assign col_ptr32 = 32'(col_ptr);
  assign col32     = 32'(col_rdata);
  assign col_ok    = (col32 < MD32);
  assign clr32     = 32'(clr_cnt_r);

  assign mk_we    = cmd.clr_step || (cmd.stamp_wr && col_ok);
  assign mk_waddr = cmd.clr_step ? clr32[MA-1:0] : col32[MA-1:0];
  assign mk_wdata = cmd.clr_step ? MARKER_EMPTY : {1'b0, stamp_r};

  mlic_ram #(
    .WIDTH (OFFSET_W),
    .DEPTH (ROW_TABLE_DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (waddr32[RA-1:0]),
    .wdata (in_value),
    .re    (cmd.row_rd_lo || cmd.row_rd_hi),
    .raddr (row_addr32[RA-1:0]),
    .rdata (row_rdata)
  );

  mlic_ram #(
    .WIDTH (COL_W),
    .DEPTH (COLUMN_TABLE_DEPTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (waddr32[CA-1:0]),
    .wdata (in_value[COL_W-1:0]),
    .re    (cmd.col_rd_a || cmd.col_rd_b),
    .raddr (col_ptr32[CA-1:0]),
    .rdata (col_rdata)
  );

  mlic_ram #(
    .WIDTH (MARKER_W),
    .DEPTH (MARKER_DEPTH)
  ) u_marker_ram (
    .clk   (clk),
    .we    (mk_we),
    .waddr (mk_waddr),
    .wdata (mk_wdata),
    .re    (cmd.mk_rd && col_ok),
    .raddr (col32[MA-1:0]),
    .rdata (mk_rdata)
  );

  // Clear sweep; reset starts a full pass over the marker store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      clr_lim_r <= MD_CNT;
    end else if (cmd.cap && (in_mode == MODE_CLEAR)) begin
      clr_cnt_r <= '0;
      clr_lim_r <= clr_lim_in;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + CLR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      stamp_r   <= in_row_number;
      ab_base_r <= in_ab_base;
      bc_base_r <= in_bc_base;
      ac_base_r <= in_ac_base;
      total_r   <= '0;
      err_r     <= 1'b0;
    end
    if (cmd.span_empty) begin
      err_r <= 1'b1;
      if (dst_b) begin
        b_ptr_r <= '0;
        b_hi_r  <= '0;
      end else begin
        a_ptr_r <= '0;
        a_hi_r  <= '0;
      end
    end
    if (cmd.span_cap_lo) begin
      lo_r <= row_rdata;
    end
    if (cmd.span_cap_hi) begin
      if (hi_over) begin
        err_r <= 1'b1;
      end
      if (dst_b) begin
        b_ptr_r <= lo_cl;
        b_hi_r  <= hi_cl;
      end else begin
        a_ptr_r <= lo_cl;
        a_hi_r  <= hi_cl;
      end
    end
    if (cmd.col_rd_a) begin
      a_ptr_r <= a_ptr_r + OFFSET_W'(1);
    end
    if (cmd.col_rd_b) begin
      b_ptr_r <= b_ptr_r + OFFSET_W'(1);
    end
    if (cmd.stamp_wr && !col_ok) begin
      err_r <= 1'b1;
    end
    if (cmd.b_lat) begin
      b_r <= col_rdata;
    end
    if (cmd.mk_rd) begin
      hit_v_r <= col_ok;
      if (!col_ok) begin
        err_r <= 1'b1;
      end
    end
    // count a stamped column, stop at the top of the range
    if (cmd.cmp && hit_v_r && (mk_rdata == {1'b0, stamp_r}) && (total_r != TOTAL_MAX)) begin
      total_r <= total_r + TOTAL_W'(1);
    end
    if (cmd.out_load) begin
      out_total_r <= total_r;
      out_err_r   <= err_r;
    end
  end

  assign sts.row_bad  = (row_inc32 >= RTD32);
  assign sts.a_more   = (a_ptr_r < a_hi_r);
  assign sts.b_more   = (b_ptr_r < b_hi_r);
  assign sts.clr_more = (clr_cnt_r < clr_lim_r);

  assign out_match_total = out_total_r;
  assign out_range_error = out_err_r;

endmodule

[rtl/core/marker_list_intersect_counter.sv]
// ----------------------------------------------------------------------------
// marker_list_intersect_counter
// Sparse row graph store with a marker array; counts stamped columns over
// the intersection of an ab-row's neighbor lists with an ac-row.
// ----------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    mode address value ab_base bc_base ac_base
//                                 row_number
//   out_chan  out  valid/ready    match_total range_error
//
// A count looks up the span of each row it walks (a row off the table is
// taken as empty), stamps the ac-row columns, then walks each ab-row
// column and the columns of its bc-row; the single-port column table read
// sets the pace of every list walk. After reset a clearing pass over the
// whole marker store runs before the first item is taken. One item is
// worked at a time; a finished result waits in the output register, and a
// count that finishes behind it holds there.
// ----------------------------------------------------------------------------
module marker_list_intersect_counter #(
  parameter int ROW_TABLE_DEPTH    = mlic_pkg::ROW_TABLE_DEPTH_DEF,
  parameter int COLUMN_TABLE_DEPTH = mlic_pkg::COLUMN_TABLE_DEPTH_DEF,
  parameter int MARKER_DEPTH       = mlic_pkg::MARKER_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mlic_in_if.sink    in_chan,
  mlic_out_if.source out_chan
);
  import mlic_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       in_ready;
  logic       out_valid;

  mlic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_mode   (in_chan.mode),
    .in_ready  (in_ready),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  mlic_dp #(
    .ROW_TABLE_DEPTH    (ROW_TABLE_DEPTH),
    .COLUMN_TABLE_DEPTH (COLUMN_TABLE_DEPTH),
    .MARKER_DEPTH       (MARKER_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_chan.mode),
    .in_address      (in_chan.address),
    .in_value        (in_chan.value),
    .in_ab_base      (in_chan.ab_base),
    .in_bc_base      (in_chan.bc_base),
    .in_ac_base      (in_chan.ac_base),
    .in_row_number   (in_chan.row_number),
    .cmd             (cmd),
    .sts             (sts),
    .out_match_total (out_chan.match_total),
    .out_range_error (out_chan.range_error)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule
